### hdl/rerm_pkg.sv
package rerm_pkg;

    localparam int AVG_W     = 17;
    localparam int PCT_W     = 14;
    localparam int DIV_NUM_W = 49;
    localparam int DIV_DEN_W = 33;
    localparam int DIV_CNT_W = 6;

    localparam logic [AVG_W-1:0] ALPHA_ONE     = 17'd65536;
    localparam logic [15:0]      WINDOW_RESET  = 16'd1000;
    localparam logic [9:0]       US_PER_MS     = 10'd1000;
    localparam logic [13:0]      PCT_SCALE     = 14'd10000;
    localparam logic [15:0]      ROUND_HALF    = 16'h8000;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic [2:0] ADDR_WINDOW = 3'd0;

    typedef struct packed {
        logic [AVG_W-1:0] low;
        logic [AVG_W-1:0] high;
    } avg_pair_t;

endpackage

### hdl/range_excursion_rate_monitor.sv
// Range excursion rate monitor.
// Input channel (in_valid / in_stall) carries one item: a command, a raw value
// with its expected minimum and maximum, a channel number and elapsed time.
// A sample item yields the value normalised to its range (Q16.16, saturated),
// the fractional part of its magnitude, and the updated below-range and
// above-range rates of that channel in hundredths of a percent. A clear item
// zeroes every channel's averages and yields an all-zero result.
// Output channel (out_valid / out_stall) carries one result item per input item.
// A sample item passes through two 49-step shift-subtract divisions in one shared
// divider (normalisation, then averaging weight), followed by a read-modify-write
// of the channel's entry in the average memory. The next item can be accepted in
// the same cycle as the result appears. A zero range skips the first division, a
// channel outside the table skips the second and yields zero rates with pct_valid
// low; a clear item goes from acceptance straight to the last step, where it
// waits for the output register.
// One item is worked on at a time; in_stall is high while it is in flight.
// The finished result sits in an output register, so the next item is accepted
// while the receiver stalls; that item then holds in its last step until the
// register frees. Reset sets window_ms to 1000 ms and marks every average zero.
// window_ms sits at byte address 0 of the APB port.
module range_excursion_rate_monitor
    import rerm_pkg::*;
#(
    parameter  int CHANNELS = 16,
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic signed [31:0] raw_value,
    input  logic signed [31:0] min_value,
    input  logic signed [31:0] max_value,
    input  logic [7:0]         channel,
    input  logic [19:0]        dt_us,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] unwrapped,
    output logic [15:0]        wrapped,
    output logic [PCT_W-1:0]   low_pct,
    output logic [PCT_W-1:0]   high_pct,
    output logic               pct_valid
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DIVQ,
        S_SATQ,
        S_DIVA,
        S_MUL,
        S_ACC,
        S_PCT,
        S_FIN
    } state_t;

    state_t state_reg;

    logic [15:0] window_reg;

    logic signed [31:0] raw_reg;
    logic signed [31:0] min_reg;
    logic signed [31:0] max_reg;
    logic [7:0]         channel_reg;
    logic [19:0]        dt_reg;

    logic               zero_range_reg;
    logic               neg_reg;
    logic [25:0]        alpha_den_reg;
    logic [AVG_W-1:0]   alpha_reg;
    logic               hit_low_reg;
    logic               hit_high_reg;
    logic [2*AVG_W-1:0] prod_low_reg;
    logic [2*AVG_W-1:0] prod_high_reg;
    logic [AVG_W-1:0]   avg_low_reg;
    logic [AVG_W-1:0]   avg_high_reg;

    logic signed [31:0] res_unwrapped_reg;
    logic [15:0]        res_wrapped_reg;
    logic [PCT_W-1:0]   res_low_reg;
    logic [PCT_W-1:0]   res_high_reg;
    logic               res_valid_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_unwrapped_reg;
    logic [15:0]        out_wrapped_reg;
    logic [PCT_W-1:0]   out_low_reg;
    logic [PCT_W-1:0]   out_high_reg;
    logic               out_pct_valid_reg;

    logic                 div_start_reg;
    logic [DIV_NUM_W-1:0] div_num_reg;
    logic [DIV_DEN_W-1:0] div_den_reg;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    logic       in_accept;
    logic       cfg_write;
    logic       mem_clear;
    avg_pair_t  mem_rd;
    avg_pair_t  mem_wr;
    logic       mem_wr_en;
    logic       in_table;
    logic [CH_W-1:0] ch_idx;

    logic signed [32:0] diff_s;
    logic signed [32:0] range_s;
    logic [32:0]        diff_mag;
    logic [32:0]        range_mag;
    logic [15:0]        window_eff;

    logic [DIV_NUM_W-1:0] quo_mag;
    logic                 quo_neg;
    logic [31:0]          mag_sat;

    logic [AVG_W-1:0]     one_minus_alpha;
    logic [2*AVG_W:0]     sum_low;
    logic [2*AVG_W:0]     sum_high;
    logic [30:0]          pct_low_sum;
    logic [30:0]          pct_high_sum;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == ADDR_WINDOW[2]) ? {16'd0, window_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_write && (paddr[2] == ADDR_WINDOW[2]))
        begin
            window_reg <= pwdata[15:0];
        end
    end

    assign in_table   = ({1'b0, channel_reg} < 9'(CHANNELS));
    assign ch_idx     = channel_reg[CH_W-1:0];
    assign mem_clear  = in_accept && (command == CMD_CLEAR);

    assign diff_s     = {raw_reg[31], raw_reg} - {min_reg[31], min_reg};
    assign range_s    = {max_reg[31], max_reg} - {min_reg[31], min_reg};
    assign diff_mag   = diff_s[32] ? 33'(-diff_s) : 33'(diff_s);
    assign range_mag  = range_s[32] ? 33'(-range_s) : 33'(range_s);
    assign window_eff = (window_reg == 16'd0) ? 16'd1 : window_reg;

    // saturate the quotient magnitude to the signed 32-bit range
    assign quo_mag = zero_range_reg ? '0 : div_quo;
    assign quo_neg = neg_reg && !zero_range_reg;
    always_comb
    begin
        if (quo_neg)
        begin
            mag_sat = (quo_mag > DIV_NUM_W'(33'h0_8000_0000)) ? 32'h8000_0000 : quo_mag[31:0];
        end
        else
        begin
            mag_sat = (quo_mag > DIV_NUM_W'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : quo_mag[31:0];
        end
    end

    assign one_minus_alpha = ALPHA_ONE - alpha_reg;

    assign sum_low  = {1'b0, prod_low_reg}
                    + (hit_low_reg ? {2'b0, alpha_reg, 16'd0} : '0)
                    + (2*AVG_W+1)'(ROUND_HALF);
    assign sum_high = {1'b0, prod_high_reg}
                    + (hit_high_reg ? {2'b0, alpha_reg, 16'd0} : '0)
                    + (2*AVG_W+1)'(ROUND_HALF);

    assign mem_wr.low  = sum_low[AVG_W+15:16];
    assign mem_wr.high = sum_high[AVG_W+15:16];
    assign mem_wr_en   = (state_reg == S_ACC);

    assign pct_low_sum  = 31'(avg_low_reg) * 31'(PCT_SCALE) + 31'(ROUND_HALF);
    assign pct_high_sum = 31'(avg_high_reg) * 31'(PCT_SCALE) + 31'(ROUND_HALF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            div_start_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
            raw_reg           <= '0;
            min_reg           <= '0;
            max_reg           <= '0;
            channel_reg       <= '0;
            dt_reg            <= '0;
            zero_range_reg    <= 1'b0;
            neg_reg           <= 1'b0;
            alpha_den_reg     <= '0;
            alpha_reg         <= '0;
            hit_low_reg       <= 1'b0;
            hit_high_reg      <= 1'b0;
            prod_low_reg      <= '0;
            prod_high_reg     <= '0;
            avg_low_reg       <= '0;
            avg_high_reg      <= '0;
            div_num_reg       <= '0;
            div_den_reg       <= '0;
            res_unwrapped_reg <= '0;
            res_wrapped_reg   <= '0;
            res_low_reg       <= '0;
            res_high_reg      <= '0;
            res_valid_reg     <= 1'b0;
            out_unwrapped_reg <= '0;
            out_wrapped_reg   <= '0;
            out_low_reg       <= '0;
            out_high_reg      <= '0;
            out_pct_valid_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (out_valid_reg && !out_stall && (state_reg != S_FIN))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        raw_reg     <= raw_value;
                        min_reg     <= min_value;
                        max_reg     <= max_value;
                        channel_reg <= channel;
                        dt_reg      <= dt_us;
                        if (command == CMD_CLEAR)
                        begin
                            res_unwrapped_reg <= '0;
                            res_wrapped_reg   <= '0;
                            res_low_reg       <= '0;
                            res_high_reg      <= '0;
                            res_valid_reg     <= 1'b0;
                            state_reg         <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_PREP;
                        end
                    end
                end

                S_PREP:
                begin
                    zero_range_reg <= (range_s == '0);
                    neg_reg        <= diff_s[32] ^ range_s[32];
                    alpha_den_reg  <= 26'(window_eff) * 26'(US_PER_MS);
                    div_num_reg    <= {diff_mag, 16'd0};
                    div_den_reg    <= range_mag;
                    if (range_s == '0)
                    begin
                        state_reg <= S_SATQ;
                    end
                    else
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIVQ;
                    end
                end

                S_DIVQ:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_SATQ;
                    end
                end

                S_SATQ:
                begin
                    res_unwrapped_reg <= quo_neg ? 32'(-mag_sat) : mag_sat;
                    res_wrapped_reg   <= mag_sat[15:0];
                    hit_low_reg       <= quo_neg && (quo_mag != '0);
                    hit_high_reg      <= !quo_neg && (quo_mag > DIV_NUM_W'(ALPHA_ONE));
                    if (in_table)
                    begin
                        div_num_reg   <= DIV_NUM_W'({dt_reg, 16'd0});
                        div_den_reg   <= DIV_DEN_W'(alpha_den_reg);
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIVA;
                    end
                    else
                    begin
                        res_low_reg   <= '0;
                        res_high_reg  <= '0;
                        res_valid_reg <= 1'b0;
                        state_reg     <= S_FIN;
                    end
                end

                S_DIVA:
                begin
                    if (div_done)
                    begin
                        alpha_reg <= (div_quo > DIV_NUM_W'(ALPHA_ONE)) ? ALPHA_ONE
                                                                       : div_quo[AVG_W-1:0];
                        state_reg <= S_MUL;
                    end
                end

                S_MUL:
                begin
                    prod_low_reg  <= (2*AVG_W)'(mem_rd.low) * (2*AVG_W)'(one_minus_alpha);
                    prod_high_reg <= (2*AVG_W)'(mem_rd.high) * (2*AVG_W)'(one_minus_alpha);
                    state_reg     <= S_ACC;
                end

                S_ACC:
                begin
                    avg_low_reg  <= mem_wr.low;
                    avg_high_reg <= mem_wr.high;
                    state_reg    <= S_PCT;
                end

                S_PCT:
                begin
                    res_low_reg   <= pct_low_sum[PCT_W+15:16];
                    res_high_reg  <= pct_high_sum[PCT_W+15:16];
                    res_valid_reg <= 1'b1;
                    state_reg     <= S_FIN;
                end

                S_FIN:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg     <= 1'b1;
                        out_unwrapped_reg <= res_unwrapped_reg;
                        out_wrapped_reg   <= res_wrapped_reg;
                        out_low_reg       <= res_low_reg;
                        out_high_reg      <= res_high_reg;
                        out_pct_valid_reg <= res_valid_reg;
                        state_reg         <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    rerm_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    rerm_avg_mem #(
        .DEPTH (CHANNELS)
    ) u_avg_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (mem_clear),
        .rd_addr (ch_idx),
        .rd_data (mem_rd),
        .wr_en   (mem_wr_en),
        .wr_addr (ch_idx),
        .wr_data (mem_wr)
    );

    assign out_valid = out_valid_reg;
    assign unwrapped = out_unwrapped_reg;
    assign wrapped   = out_wrapped_reg;
    assign low_pct   = out_low_reg;
    assign high_pct  = out_high_reg;
    assign pct_valid = out_pct_valid_reg;

endmodule

### hdl/rerm_divider.sv
module rerm_divider
    import rerm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quo
);

    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0]   trial;
    logic                 fits;
    logic [DIV_DEN_W:0]   diff;

    assign trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift one quotient bit in per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

### hdl/rerm_avg_mem.sv
module rerm_avg_mem
    import rerm_pkg::*;
#(
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic [AW-1:0] rd_addr,
    output avg_pair_t     rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  avg_pair_t     wr_data
);

    avg_pair_t        mem [DEPTH];
    avg_pair_t        mem_q_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg <= mem[rd_addr];
    end

    // an entry not written since reset or clear reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? mem_q_reg : '0;

endmodule

### tb/range_excursion_rate_monitor_test.sv
module range_excursion_rate_monitor_test;
    import rerm_pkg::*;

    localparam int CHANNELS         = 16;
    localparam int HOLDOFF_CYCLES   = 600;
    localparam int QUIET_LIMIT      = 5000;
    localparam int ITEMS_PER_PHASE  = 175;
    localparam int DRAIN_CYCLES     = 150;
    localparam int PHASES           = 8;

    typedef struct packed {
        logic               command;
        logic signed [31:0] raw;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [7:0]         chan;
        logic [19:0]        dt;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] unwrapped;
        logic [15:0]        wrapped;
        logic [PCT_W-1:0]   low_pct;
        logic [PCT_W-1:0]   high_pct;
        logic               pct_valid;
    } rates_t;

    class excursion_tracker;
        logic [15:0]      window;
        logic [AVG_W-1:0] avg_low [CHANNELS];
        logic [AVG_W-1:0] avg_high [CHANNELS];
        rates_t           expected_rates [$];
        int               errors;

        function new();
            window = WINDOW_RESET;
            errors = 0;
            clear_averages();
        endfunction

        function void clear_averages();
            for (int i = 0; i < CHANNELS; i++)
            begin
                avg_low[i] = '0;
                avg_high[i] = '0;
            end
        endfunction

        function logic [AVG_W-1:0] ema(logic [AVG_W-1:0] avg, longint alpha, bit hit);
            longint acc;
            acc = longint'(avg) * (65536 - alpha) + (hit ? 65536 * alpha : 0) + 32768;
            return AVG_W'(acc >>> 16);
        endfunction

        function logic [PCT_W-1:0] to_pct(logic [AVG_W-1:0] avg);
            return PCT_W'((longint'(avg) * 10000 + 32768) >>> 16);
        endfunction

        function void note_input(sample_t s);
            longint num;
            longint den;
            longint q;
            longint mag;
            longint w;
            longint alpha;
            rates_t r;
            r = '0;
            if (s.command == CMD_CLEAR)
            begin
                clear_averages();
                expected_rates.push_back(r);
                return;
            end
            den = longint'($signed(s.hi)) - longint'($signed(s.lo));
            if (den == 0)
                q = 0;
            else
            begin
                num = (longint'($signed(s.raw)) - longint'($signed(s.lo))) * 65536;
                q = num / den;
                if (q > 64'sd2147483647)
                    q = 64'sd2147483647;
                if (q < -64'sd2147483648)
                    q = -64'sd2147483648;
            end
            mag = (q < 0) ? -q : q;
            r.unwrapped = 32'(q);
            r.wrapped = mag[15:0];
            if (s.chan < CHANNELS)
            begin
                w = (window == 0) ? 1 : longint'(window);
                alpha = (longint'(s.dt) << 16) / (w * 1000);
                if (alpha > 65536)
                    alpha = 65536;
                avg_low[s.chan] = ema(avg_low[s.chan], alpha, q < 0);
                avg_high[s.chan] = ema(avg_high[s.chan], alpha, q > 65536);
                r.low_pct = to_pct(avg_low[s.chan]);
                r.high_pct = to_pct(avg_high[s.chan]);
                r.pct_valid = 1'b1;
            end
            expected_rates.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("ERROR: %s", what);
            errors++;
        endtask

        task check_result(rates_t got);
            rates_t want;
            if (expected_rates.size() == 0)
            begin
                report_mismatch("result with no item outstanding");
                return;
            end
            want = expected_rates.pop_front();
            if (got.unwrapped !== want.unwrapped)
                report_mismatch($sformatf("unwrapped got %0d wanted %0d",
                                          got.unwrapped, want.unwrapped));
            if (got.wrapped !== want.wrapped)
                report_mismatch($sformatf("wrapped got %h wanted %h", got.wrapped, want.wrapped));
            if (got.low_pct !== want.low_pct)
                report_mismatch($sformatf("low_pct got %0d wanted %0d",
                                          got.low_pct, want.low_pct));
            if (got.high_pct !== want.high_pct)
                report_mismatch($sformatf("high_pct got %0d wanted %0d",
                                          got.high_pct, want.high_pct));
            if (got.pct_valid !== want.pct_valid)
                report_mismatch($sformatf("pct_valid got %b wanted %b",
                                          got.pct_valid, want.pct_valid));
        endtask

        function int pending();
            return expected_rates.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               command = CMD_SAMPLE;
    logic signed [31:0] raw_value = '0;
    logic signed [31:0] min_value = '0;
    logic signed [31:0] max_value = '0;
    logic [7:0]         channel = '0;
    logic [19:0]        dt_us = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] unwrapped;
    logic [15:0]        wrapped;
    logic [PCT_W-1:0]   low_pct;
    logic [PCT_W-1:0]   high_pct;
    logic               pct_valid;

    excursion_tracker tracker;
    int               idle_mode = 0;
    bit               hold_request = 1'b0;
    int               hold_left = 0;
    int               quiet = 0;
    logic [15:0]      window_plan [PHASES] = '{16'd1, 16'd65535, 16'd1000, 16'd0,
                                               16'd250, 16'd40000, 16'd7, 16'd1000};

    range_excursion_rate_monitor #(.CHANNELS(CHANNELS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .raw_value (raw_value),
        .min_value (min_value),
        .max_value (max_value),
        .channel   (channel),
        .dt_us     (dt_us),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .unwrapped (unwrapped),
        .wrapped   (wrapped),
        .low_pct   (low_pct),
        .high_pct  (high_pct),
        .pct_valid (pct_valid)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic bit sender_idles();
        return (idle_mode == 1 && $urandom_range(0, 99) < 76) ||
               (idle_mode == 3 && $urandom_range(0, 99) < 21);
    endfunction

    function automatic bit receiver_idles();
        return (idle_mode == 2 && $urandom_range(0, 99) < 76) ||
               (idle_mode == 3 && $urandom_range(0, 99) < 21);
    endfunction

    function automatic sample_t mk(logic cmd, logic [31:0] raw, logic [31:0] lo,
                                   logic [31:0] hi, logic [7:0] ch, logic [19:0] dt);
        sample_t s;
        s.command = cmd;
        s.raw = raw;
        s.lo = lo;
        s.hi = hi;
        s.chan = ch;
        s.dt = dt;
        return s;
    endfunction

    function automatic sample_t random_item();
        sample_t s;
        longint  lo;
        longint  span;
        longint  off;
        int      pick;
        s.command = ($urandom_range(0, 99) < 3) ? CMD_CLEAR : CMD_SAMPLE;
        s.chan = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, CHANNELS - 1))
                                              : 8'($urandom_range(0, 255));
        s.dt = 20'($urandom() >> $urandom_range(12, 31));
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            s.raw = $urandom();
            s.lo = $urandom();
            s.hi = $urandom();
        end
        else if (pick == 2)
        begin
            s.raw = $urandom();
            s.lo = $urandom();
            s.hi = s.lo;
        end
        else
        begin
            lo = longint'($signed($urandom())) >>> $urandom_range(0, 16);
            span = longint'($urandom() >> $urandom_range(8, 31)) + 1;
            off = longint'($urandom_range(0, 65535)) * (2 * span) / 65536 - span / 2;
            s.lo = 32'(lo);
            s.hi = ($urandom_range(0, 7) == 0) ? 32'(lo - span) : 32'(lo + span);
            s.raw = 32'(lo + off);
        end
        return s;
    endfunction

    task automatic send_item(input sample_t s);
        while (sender_idles())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= s.command;
        raw_value <= s.raw;
        min_value <= s.lo;
        max_value <= s.hi;
        channel <= s.chan;
        dt_us <= s.dt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_input(s);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_window(input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_WINDOW;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tracker.window = value;
    endtask

    always @(posedge clk)
    begin : receiver
        rates_t got;
        if (out_valid && !out_stall)
        begin
            got.unwrapped = unwrapped;
            got.wrapped = wrapped;
            got.low_pct = low_pct;
            got.high_pct = high_pct;
            got.pct_valid = pct_valid;
            tracker.check_result(got);
        end
        if (hold_request)
        begin
            hold_left = HOLDOFF_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= receiver_idles();
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (!in_valid && tracker.pending() == 0))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("range_excursion_rate_monitor: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        tracker = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(mk(CMD_SAMPLE, 32'h0000_8000, 32'h0, 32'h0001_0000, 8'd0, 20'd0));
        send_item(mk(CMD_SAMPLE, 32'hFFFF_0000, 32'h0, 32'h0001_0000, 8'd0, 20'd1000000));
        send_item(mk(CMD_SAMPLE, 32'h0003_0000, 32'h0, 32'h0001_0000, 8'd0, 20'hFFFFF));
        send_item(mk(CMD_SAMPLE, 32'h0001_0000, 32'h0, 32'h0001_0000, 8'd15, 20'd500000));
        send_item(mk(CMD_SAMPLE, 32'h7FFF_FFFF, 32'h7B, 32'h7B, 8'd3, 20'd1234));
        send_item(mk(CMD_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 8'd1, 20'd250000));
        send_item(mk(CMD_SAMPLE, 32'h8000_0000, 32'h0, 32'h1, 8'd2, 20'd250000));
        send_item(mk(CMD_SAMPLE, 32'h0001_0000, 32'h0005_0000, 32'h0, 8'd4, 20'd100000));
        send_item(mk(CMD_SAMPLE, 32'h0002_C000, 32'h0, 32'h0001_0000, 8'd5, 20'd10));
        send_item(mk(CMD_SAMPLE, 32'hFFFE_C000, 32'h0, 32'h0001_0000, 8'd5, 20'd10));
        send_item(mk(CMD_SAMPLE, 32'h0000_4000, 32'h0, 32'h0001_0000, 8'd16, 20'd999));
        send_item(mk(CMD_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 8'd255,
                     20'hFFFFF));
        send_item(mk(CMD_SAMPLE, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'hFF,
                     20'hFFFFF));
        send_item(mk(CMD_SAMPLE, 32'h0, 32'h0, 32'h0, 8'd0, 20'd0));
        send_item(mk(CMD_CLEAR, 32'hFFFF_FFFF, 32'h1234_5678, 32'h7FFF_FFFF, 8'd0, 20'hFFFFF));
        send_item(mk(CMD_SAMPLE, 32'hFFFF_0000, 32'h0, 32'h0001_0000, 8'd0, 20'd1));
        send_item(mk(CMD_SAMPLE, 32'h0003_0000, 32'h0, 32'h0001_0000, 8'd15, 20'd1000));
        send_item(mk(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 8'd0, 20'd0));
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            write_window(window_plan[p]);
            idle_mode = p % 4;
            // hold the output back while items keep coming
            if (p == 0)
                hold_request = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_item(random_item());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("range_excursion_rate_monitor: match");
        else
            $display("range_excursion_rate_monitor: mismatch");
        $finish;
    end

endmodule
